// File: hw/rtl/iee_pkg.sv
// Package with the shared types, character codes and helper functions of the expression evaluator.
package iee_pkg;

	localparam int NEST_DEPTH_DEF  = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PCT   = 8'h25;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_DIV0 = 2'd1;
	localparam logic [1:0] ERR_NEST = 2'd2;
	localparam logic [1:0] ERR_FORM = 2'd3;

	localparam logic [1:0] LO_NONE = 2'd0;
	localparam logic [1:0] LO_ADD  = 2'd1;
	localparam logic [1:0] LO_SUB  = 2'd2;

	localparam logic [1:0] HI_NONE = 2'd0;
	localparam logic [1:0] HI_MUL  = 2'd1;
	localparam logic [1:0] HI_DIV  = 2'd2;
	localparam logic [1:0] HI_REM  = 2'd3;

	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_DIGIT,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_LOW,
		CLS_HIGH,
		CLS_END
	} char_class_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_REM
	} alu_op_t;

	typedef enum logic [1:0] {
		AS_IDLE,
		AS_RUN,
		AS_FIX,
		AS_DONE
	} alu_state_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_CHAR,
		EM_HIGH,
		EM_LOW,
		EM_FINAL
	} emit_kind_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_DECODE,
		CS_EMIT_CHAR,
		CS_DEL_CHK,
		CS_DEL_LD,
		CS_DEL_WAIT,
		CS_DEL_EMIT,
		CS_CL_RT,
		CS_CL_LT,
		CS_CL_LL,
		CS_CL_WAIT,
		CS_CL_EMIT,
		CS_CL_DONE,
		CS_FINAL,
		CS_FLUSH,
		CS_FLUSH_CLR
	} ctrl_state_t;

	typedef struct packed {
		logic       set_err;
		logic [1:0] err_code;
		logic       load_digit;
		logic       push;
		logic       pop;
		logic       set_high;
		logic       set_low;
		logic       set_term;
		logic       raddr_term;
		logic       we;
		logic       waddr_term;
		logic       alu_start;
		logic       alu_high;
		logic       ld_opa;
		logic       ld_opb;
		emit_kind_t emit;
		logic       flush;
		logic       clear;
	} dp_cmd_t;

	typedef struct packed {
		char_class_t cls;
		logic        in_valid;
		logic        want_op;
		logic        lvl_zero;
		logic        lvl_max;
		logic        err_nz;
		logic        lo_nz;
		logic        hi_nz;
		logic        emit_ok;
		logic        alu_done;
	} dp_status_t;

	function automatic char_class_t classify(input logic [7:0] ch);
		char_class_t c;
		c = CLS_OTHER;
		if (ch >= CH_ONE && ch <= CH_NINE) c = CLS_DIGIT;
		else if (ch == CH_LPAR) c = CLS_OPEN;
		else if (ch == CH_RPAR) c = CLS_CLOSE;
		else if (ch == CH_PLUS || ch == CH_MINUS) c = CLS_LOW;
		else if (ch == CH_STAR || ch == CH_SLASH || ch == CH_PCT) c = CLS_HIGH;
		else if (ch == CH_HASH) c = CLS_END;
		return c;
	endfunction

	function automatic logic [7:0] low_sym(input logic [1:0] code);
		logic [7:0] s;
		case (code)
			LO_ADD: s = CH_PLUS;
			LO_SUB: s = CH_MINUS;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] high_sym(input logic [1:0] code);
		logic [7:0] s;
		case (code)
			HI_MUL: s = CH_STAR;
			HI_DIV: s = CH_SLASH;
			HI_REM: s = CH_PCT;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// File: hw/rtl/iee_if.sv
// Handshake interfaces for the character input channel and the result output channel.
interface iee_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface iee_result_if;
	logic               valid;
	logic               ready;
	logic        [7:0]  symbol;
	logic               symbol_valid;
	logic signed [31:0] value;
	logic               done_res;
	logic        [1:0]  error;
	logic               last;

	modport source (output valid, output symbol, output symbol_valid, output value,
		output done_res, output error, output last, input ready);
	modport sink (input valid, input symbol, input symbol_valid, input value,
		input done_res, input error, input last, output ready);
endinterface

// File: hw/rtl/infix_expression_evaluator.sv
// Top level of the infix expression evaluator: controller, datapath and channel wiring.
// Each accepted item is sequenced by the controller until its last result is staged. Applying
// * / or % uses the one-bit-per-cycle ALU, and / or % adds a sign fixup step after its iterations;
// the worst case is a ) that closes a sum and applies / or %.
// Throughput: one item at a time; the next item is taken once the current one is finished,
// even while its last result still waits in the output register. Reset clears the control
// state, nesting level and error latch; frame values need no clearing.
module infix_expression_evaluator import iee_pkg::*; #(
	parameter int NEST_DEPTH  = NEST_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	iee_char_if.sink     chars,
	iee_result_if.source results
);
	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_ready;

	iee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	iee_dp #(
		.NEST_DEPTH  (NEST_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status),
		.chars    (chars),
		.results  (results)
	);
endmodule

// File: hw/rtl/iee_ram.sv
// Generic single write port RAM with a registered read port.
module iee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hw/rtl/iee_alu.sv
// Multi-cycle arithmetic unit: add, subtract, shift-add multiply, signed restoring divide.
module iee_alu import iee_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  alu_op_t                op,
	input  logic [VALUE_WIDTH-1:0] a,
	input  logic [VALUE_WIDTH-1:0] b,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] res,
	output logic                   dz
);
	localparam int W   = VALUE_WIDTH;
	localparam int CW  = $clog2(W + 1);

	alu_state_t       st_q, st_d;
	alu_op_t          op_q;
	logic [W-1:0]     acc_q, x_q, y_q;
	logic [CW-1:0]    cnt_q;
	logic             qneg_q, rneg_q, dz_q;
	logic [W-1:0]     rem2;
	logic             ge;
	logic [W-1:0]     abs_a, abs_b;

	assign abs_a = a[W-1] ? (~a + 1'b1) : a;
	assign abs_b = b[W-1] ? (~b + 1'b1) : b;
	assign rem2  = {acc_q[W-2:0], x_q[W-1]};
	assign ge    = (rem2 >= y_q);

	always_comb begin
		st_d = st_q;
		case (st_q)
			AS_IDLE: begin
				if (start) begin
					if (op == ALU_ADD || op == ALU_SUB || b == '0) st_d = AS_DONE;
					else st_d = AS_RUN;
				end
			end
			AS_RUN: begin
				if (cnt_q == CW'(1)) begin
					st_d = (op_q == ALU_MUL) ? AS_DONE : AS_FIX;
				end
			end
			AS_FIX: st_d = AS_DONE;
			AS_DONE: st_d = AS_IDLE;
			default: st_d = AS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= AS_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			AS_IDLE: begin
				if (start) begin
					op_q   <= op;
					dz_q   <= 1'b0;
					cnt_q  <= CW'(W);
					qneg_q <= a[W-1] ^ b[W-1];
					rneg_q <= a[W-1];
					case (op)
						ALU_ADD: acc_q <= a + b;
						ALU_SUB: acc_q <= a - b;
						ALU_MUL: begin
							acc_q <= '0;
							x_q   <= a;
							y_q   <= b;
						end
						default: begin
							acc_q <= '0;
							x_q   <= abs_a;
							y_q   <= abs_b;
							dz_q  <= (b == '0);
						end
					endcase
				end
			end
			AS_RUN: begin
				cnt_q <= cnt_q - 1'b1;
				if (op_q == ALU_MUL) begin
					if (y_q[0]) acc_q <= acc_q + x_q;
					x_q <= {x_q[W-2:0], 1'b0};
					y_q <= {1'b0, y_q[W-1:1]};
				end else begin
					acc_q <= ge ? (rem2 - y_q) : rem2;
					x_q   <= {x_q[W-2:0], ge};
				end
			end
			AS_FIX: begin
				if (op_q == ALU_DIV) acc_q <= qneg_q ? (~x_q + 1'b1) : x_q;
				else acc_q <= rneg_q ? (~acc_q + 1'b1) : acc_q;
			end
			default: begin
			end
		endcase
	end

	assign done = (st_q == AS_DONE);
	assign res  = acc_q;
	assign dz   = dz_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != AS_IDLE) |-> !start)
		else $error("ALU started while busy.");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("ALU done held for more than one cycle.");
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == AS_RUN) |-> (cnt_q != '0))
		else $error("ALU iteration count ran out.");
endmodule

// File: hw/rtl/iee_dp.sv
// Datapath: frame storage, nesting level, error latch, operands, and result staging.
module iee_dp import iee_pkg::*; #(
	parameter int NEST_DEPTH  = NEST_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_ready,
	input  dp_cmd_t      cmd,
	output dp_status_t   status,
	iee_char_if.sink     chars,
	iee_result_if.source results
);
	localparam int W      = VALUE_WIDTH;
	localparam int LVL_W  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
	localparam int MEM_D  = 2 * NEST_DEPTH;
	localparam int MEM_AW = $clog2(MEM_D);

	logic [7:0]        ch_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [1:0]        err_q;
	logic [4:0]        ctrl_q [NEST_DEPTH];
	logic [W-1:0]      opa_q, opb_q;
	logic [W-1:0]      alu_a;
	logic [W-1:0]      rdata;
	logic [MEM_AW-1:0] raddr, waddr;
	logic [4:0]        cur;
	logic [1:0]        lo, hi;
	alu_op_t           alu_op;
	logic              alu_done, alu_dz;
	logic [W-1:0]      alu_res;

	logic              pend_v_q;
	logic [7:0]        pend_sym_q;
	logic              pend_sv_q;
	logic [31:0]       pend_val_q;
	logic              pend_done_q;
	logic [1:0]        pend_err_q;

	logic              out_v_q;
	logic [7:0]        out_sym_q;
	logic              out_sv_q;
	logic [31:0]       out_val_q;
	logic              out_done_q;
	logic [1:0]        out_err_q;
	logic              out_last_q;
	logic              out_free, push_out;

	logic [7:0]        new_sym;
	logic              new_sv;
	logic [31:0]       new_val;
	logic              new_done;
	logic [1:0]        new_err;

	function automatic logic [1:0] classify_high(input logic [7:0] ch);
		logic [1:0] h;
		if (ch == CH_STAR) h = HI_MUL;
		else if (ch == CH_SLASH) h = HI_DIV;
		else h = HI_REM;
		return h;
	endfunction

	assign chars.ready = in_ready;
	assign cur = ctrl_q[lvl_q];
	assign lo  = cur[1:0];
	assign hi  = cur[3:2];

	assign raddr = MEM_AW'({lvl_q, cmd.raddr_term});
	assign waddr = MEM_AW'({lvl_q, cmd.waddr_term});

	// The ALU takes its left operand in the same cycle as it is read from the frame store.
	assign alu_a = cmd.ld_opa ? rdata : opa_q;

	always_comb begin
		if (cmd.alu_high) begin
			case (hi)
				HI_MUL: alu_op = ALU_MUL;
				HI_DIV: alu_op = ALU_DIV;
				default: alu_op = ALU_REM;
			endcase
		end else begin
			alu_op = (lo == LO_ADD) ? ALU_ADD : ALU_SUB;
		end
	end

	iee_ram #(.WIDTH(W), .DEPTH(MEM_D)) u_frames (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (waddr),
		.wdata (opb_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	iee_alu #(.VALUE_WIDTH(W)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.alu_start),
		.op     (alu_op),
		.a      (alu_a),
		.b      (opb_q),
		.done   (alu_done),
		.res    (alu_res),
		.dz     (alu_dz)
	);

	always_ff @(posedge clk) begin
		if (chars.valid && in_ready) ch_q <= chars.char_code;
		if (cmd.ld_opa) opa_q <= rdata;
		if (alu_done) opb_q <= alu_res;
		else if (cmd.ld_opb) opb_q <= rdata;
		else if (cmd.load_digit) opb_q <= W'(ch_q[3:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			err_q <= ERR_NONE;
			for (int i = 0; i < NEST_DEPTH; i++) ctrl_q[i] <= '0;
		end else if (cmd.clear) begin
			lvl_q <= '0;
			err_q <= ERR_NONE;
			for (int i = 0; i < NEST_DEPTH; i++) ctrl_q[i] <= '0;
		end else begin
			if (cmd.set_err) err_q <= cmd.err_code;
			else if (alu_done && alu_dz && err_q == ERR_NONE) err_q <= ERR_DIV0;
			if (cmd.push) begin
				ctrl_q[lvl_q + 1'b1] <= '0;
				lvl_q <= lvl_q + 1'b1;
			end else if (cmd.pop) begin
				ctrl_q[lvl_q] <= '0;
				lvl_q <= lvl_q - 1'b1;
			end else if (cmd.set_high) begin
				ctrl_q[lvl_q] <= {1'b0, classify_high(ch_q), lo};
			end else if (cmd.set_low) begin
				ctrl_q[lvl_q] <= {3'b000, (ch_q == CH_PLUS) ? LO_ADD : LO_SUB};
			end else if (cmd.set_term) begin
				ctrl_q[lvl_q] <= {1'b1, HI_NONE, lo};
			end
		end
	end

	always_comb begin
		new_sym  = 8'h00;
		new_sv   = 1'b1;
		new_val  = '0;
		new_done = 1'b0;
		new_err  = ERR_NONE;
		case (cmd.emit)
			EM_CHAR: new_sym = ch_q;
			EM_HIGH: new_sym = high_sym(hi);
			EM_LOW:  new_sym = low_sym(lo);
			EM_FINAL: begin
				new_sv   = 1'b0;
				new_done = 1'b1;
				new_err  = err_q;
				new_val  = (err_q == ERR_NONE) ? 32'(opb_q) : 32'd0;
			end
			default: new_sv = 1'b0;
		endcase
	end

	assign out_free = !out_v_q || results.ready;
	assign push_out = pend_v_q && ((cmd.emit != EM_NONE) || cmd.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.emit != EM_NONE) pend_v_q <= 1'b1;
			else if (cmd.flush) pend_v_q <= 1'b0;
			if (push_out) out_v_q <= 1'b1;
			else if (results.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != EM_NONE) begin
			pend_sym_q  <= new_sym;
			pend_sv_q   <= new_sv;
			pend_val_q  <= new_val;
			pend_done_q <= new_done;
			pend_err_q  <= new_err;
		end
		if (push_out) begin
			out_sym_q  <= pend_sym_q;
			out_sv_q   <= pend_sv_q;
			out_val_q  <= pend_val_q;
			out_done_q <= pend_done_q;
			out_err_q  <= pend_err_q;
			out_last_q <= cmd.flush;
		end
	end

	assign results.valid        = out_v_q;
	assign results.symbol       = out_sym_q;
	assign results.symbol_valid = out_sv_q;
	assign results.value        = out_val_q;
	assign results.done_res     = out_done_q;
	assign results.error        = out_err_q;
	assign results.last         = out_last_q;

	assign status.cls      = classify(ch_q);
	assign status.in_valid = chars.valid;
	assign status.want_op  = cur[4];
	assign status.lvl_zero = (lvl_q == '0);
	assign status.lvl_max  = (lvl_q == LVL_W'(NEST_DEPTH - 1));
	assign status.err_nz   = (err_q != ERR_NONE);
	assign status.lo_nz    = (lo != LO_NONE);
	assign status.hi_nz    = (hi != HI_NONE);
	assign status.emit_ok  = !pend_v_q || out_free;
	assign status.alu_done = alu_done;

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE && !cmd.clear) |=> (err_q == $past(err_q)))
		else $error("Latched error changed before the expression ended.");
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LVL_W'(NEST_DEPTH - 1))
		else $error("Nesting level beyond the frame stack.");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push_out |-> out_free)
		else $error("Result register overwritten before it was taken.");
endmodule

// File: hw/rtl/iee_ctrl.sv
// Controller state machine that sequences the datapath for each input item.
module iee_ctrl import iee_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       in_ready
);
	ctrl_state_t st_q, st_d;

	always_comb begin
		st_d = st_q;
		case (st_q)
			CS_IDLE: if (status.in_valid) st_d = CS_DECODE;
			CS_DECODE: begin
				if (status.err_nz) begin
					st_d = (status.cls == CLS_END) ? CS_FINAL : CS_IDLE;
				end else begin
					case (status.cls)
						CLS_DIGIT: st_d = status.want_op ? CS_IDLE : CS_EMIT_CHAR;
						CLS_LOW: st_d = status.want_op ? CS_CL_RT : CS_IDLE;
						CLS_CLOSE: begin
							st_d = (status.want_op && !status.lvl_zero) ? CS_CL_RT : CS_IDLE;
						end
						CLS_END: begin
							st_d = (status.want_op && status.lvl_zero) ? CS_CL_RT : CS_FINAL;
						end
						default: st_d = CS_IDLE;
					endcase
				end
			end
			CS_EMIT_CHAR: if (status.emit_ok) st_d = CS_DEL_CHK;
			CS_DEL_CHK: st_d = status.hi_nz ? CS_DEL_LD : CS_FLUSH;
			CS_DEL_LD: st_d = CS_DEL_WAIT;
			CS_DEL_WAIT: if (status.alu_done) st_d = CS_DEL_EMIT;
			CS_DEL_EMIT: if (status.emit_ok) st_d = CS_FLUSH;
			CS_CL_RT: st_d = CS_CL_LT;
			CS_CL_LT: st_d = status.lo_nz ? CS_CL_LL : CS_CL_DONE;
			CS_CL_LL: st_d = CS_CL_WAIT;
			CS_CL_WAIT: if (status.alu_done) st_d = CS_CL_EMIT;
			CS_CL_EMIT: if (status.emit_ok) st_d = CS_CL_DONE;
			CS_CL_DONE: begin
				case (status.cls)
					CLS_LOW: st_d = CS_FLUSH;
					CLS_CLOSE: st_d = CS_DEL_CHK;
					default: st_d = CS_FINAL;
				endcase
			end
			CS_FINAL: if (status.emit_ok) st_d = CS_FLUSH_CLR;
			CS_FLUSH: if (status.emit_ok) st_d = CS_IDLE;
			CS_FLUSH_CLR: if (status.emit_ok) st_d = CS_IDLE;
			default: st_d = CS_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.emit = EM_NONE;
		in_ready = 1'b0;
		case (st_q)
			CS_IDLE: in_ready = 1'b1;
			CS_DECODE: begin
				if (!status.err_nz) begin
					case (status.cls)
						CLS_DIGIT: begin
							if (status.want_op) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = ERR_FORM;
							end else begin
								cmd.load_digit = 1'b1;
							end
						end
						CLS_OPEN: begin
							if (status.want_op) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = ERR_FORM;
							end else if (status.lvl_max) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = ERR_NEST;
							end else begin
								cmd.push = 1'b1;
							end
						end
						CLS_LOW: begin
							cmd.set_err  = !status.want_op;
							cmd.err_code = ERR_FORM;
						end
						CLS_HIGH: begin
							cmd.set_err  = !status.want_op;
							cmd.err_code = ERR_FORM;
							cmd.set_high = status.want_op;
						end
						CLS_CLOSE: begin
							cmd.set_err  = !status.want_op || status.lvl_zero;
							cmd.err_code = ERR_FORM;
						end
						CLS_END: begin
							cmd.set_err  = !status.want_op || !status.lvl_zero;
							cmd.err_code = ERR_FORM;
						end
						default: begin
						end
					endcase
				end
			end
			CS_EMIT_CHAR: if (status.emit_ok) cmd.emit = EM_CHAR;
			CS_DEL_CHK: begin
				cmd.raddr_term = 1'b1;
				if (!status.hi_nz) begin
					cmd.we         = 1'b1;
					cmd.waddr_term = 1'b1;
					cmd.set_term   = 1'b1;
				end
			end
			CS_DEL_LD: begin
				cmd.ld_opa    = 1'b1;
				cmd.alu_start = 1'b1;
				cmd.alu_high  = 1'b1;
			end
			CS_DEL_EMIT: begin
				if (status.emit_ok) begin
					cmd.emit       = EM_HIGH;
					cmd.we         = 1'b1;
					cmd.waddr_term = 1'b1;
					cmd.set_term   = 1'b1;
				end
			end
			CS_CL_RT: cmd.raddr_term = 1'b1;
			CS_CL_LT: cmd.ld_opb = 1'b1;
			CS_CL_LL: begin
				cmd.ld_opa    = 1'b1;
				cmd.alu_start = 1'b1;
			end
			CS_CL_EMIT: if (status.emit_ok) cmd.emit = EM_LOW;
			CS_CL_DONE: begin
				case (status.cls)
					CLS_LOW: begin
						cmd.we      = 1'b1;
						cmd.set_low = 1'b1;
					end
					CLS_CLOSE: cmd.pop = 1'b1;
					default: begin
					end
				endcase
			end
			CS_FINAL: if (status.emit_ok) cmd.emit = EM_FINAL;
			CS_FLUSH: cmd.flush = status.emit_ok;
			CS_FLUSH_CLR: begin
				cmd.flush = status.emit_ok;
				cmd.clear = status.emit_ok;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CS_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!((cmd.emit != EM_NONE) && cmd.flush))
		else $error("Emit and flush requested together.");
	a_alu_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alu_start |=> (st_q == CS_DEL_WAIT || st_q == CS_CL_WAIT))
		else $error("Arithmetic started without waiting for it.");
	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> $past(st_q == CS_FINAL || st_q == CS_FLUSH_CLR))
		else $error("State cleared outside the end of an expression.");
endmodule
